FILE: hdl/rdz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdz_pkg
// Shared types and constants of the radial dead-zone rescaler.
// ----------------------------------------------------------------------------
package rdz_pkg;

    localparam int FULL_SCALE_DEF = 32767;
    localparam int DZ_W           = 15;
    localparam logic [DZ_W-1:0] DZ_RESET = 15'd1024;

    // Magnitude is at most 46340, so one 16-bit root of a 32-bit sum.
    localparam int AXIS_W = 16;
    localparam int SUM_W  = 32;
    localparam int MAG_W  = 16;
    // Numerator: |axis|*FULL_SCALE*(mag-dz) < 2^47, denominator mag*span < 2^31.
    localparam int NUM_W  = 47;
    localparam int DEN_W  = 31;
    localparam int QUO_W  = 16;

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
    } t_stick_in;

    typedef struct packed {
        logic signed [15:0] scaled_x;
        logic signed [15:0] scaled_y;
        logic               in_dead_zone;
    } t_stick_out;

endpackage
`default_nettype wire

FILE: hdl/rdz_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdz_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rdz_isqrt #(
    parameter int SB_W = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rdz_pkg::SUM_W-1:0]  i_sum,
    input  wire logic [SB_W-1:0]            i_sb,
    output logic                            o_valid,
    output logic [rdz_pkg::MAG_W-1:0]       o_mag,
    output logic [SB_W-1:0]                 o_sb
);
    import rdz_pkg::*;

    localparam int STAGES = MAG_W;

    logic             r_v   [0:STAGES];
    logic [SUM_W-1:0] r_rem [0:STAGES];
    logic [SUM_W-1:0] r_res [0:STAGES];
    logic [SB_W-1:0]  r_sb  [0:STAGES];

    always_comb begin
        r_v[0]   = i_valid;
        r_rem[0] = i_sum;
        r_res[0] = '0;
        r_sb[0]  = i_sb;
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] n_rem;
        logic [SUM_W-1:0] n_res;

        always_comb begin
            trial = r_res[k] + BIT;
            if (r_rem[k] >= trial) begin
                n_rem = r_rem[k] - trial;
                n_res = (r_res[k] >> 1) + BIT;
            end else begin
                n_rem = r_rem[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_res[k+1] <= n_res;
                r_sb[k+1]  <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_mag   = r_res[STAGES][MAG_W-1:0];
    assign o_sb    = r_sb[STAGES];

endmodule
`default_nettype wire

FILE: hdl/rdz_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdz_div
// Pipelined restoring divider with an overflow check stage in front.
// ----------------------------------------------------------------------------
module rdz_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [rdz_pkg::NUM_W-1:0] i_num,
    input  wire logic [rdz_pkg::DEN_W-1:0] i_den,
    output logic [rdz_pkg::QUO_W-1:0]      o_quo,
    output logic                           o_sat
);
    import rdz_pkg::*;

    localparam int REM_W = NUM_W + 1;

    logic [REM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_sat [0:QUO_W];

    // The quotient overflows 16 bits when num >= den * 2^16.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_sat[0] <= ({1'b0, i_num} >= {i_den, {QUO_W{1'b0}}});
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
        localparam int SH = QUO_W - j;
        logic [REM_W-1:0] dsh;
        logic             take;

        assign dsh  = REM_W'(r_den[j-1]) << SH;
        assign take = r_rem[j-1] >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? r_rem[j-1] - dsh : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_quo[j] <= r_quo[j-1] | (QUO_W'(take) << SH);
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_sat = r_sat[QUO_W];

endmodule
`default_nettype wire

FILE: hdl/radial_deadzone_rescaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radial_deadzone_rescaler
// Radial scaled dead zone for one signed two-axis stick sample.
// ----------------------------------------------------------------------------
// Usage: a stick word enters on i_valid/i_data and is accepted at a clock
// edge with i_valid high and o_stall low. The result word leaves on
// o_valid/o_data and is taken at an edge with o_valid high and i_stall low.
// The dead-zone radius is written through i_cfg_we/i_cfg_data while the
// block is idle; it resets to 1024.
// From acceptance to o_valid a word passes the input, squaring and summing
// stages, sixteen root stages, the numerator and denominator stages,
// seventeen divider stages and one output stage.
// Throughput is one word per cycle unless the receiver stalls; each stage
// is a register, so a new word enters each cycle as earlier ones move on.
// Reset clears all valid bits, so the pipeline comes up empty.
// When the receiver stalls a waiting result, the whole pipeline holds in
// place and o_stall rises; no word is lost or repeated, and bubbles keep
// moving forward while the output stage is empty.
// ----------------------------------------------------------------------------
module radial_deadzone_rescaler #(
    parameter int FULL_SCALE = rdz_pkg::FULL_SCALE_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire rdz_pkg::t_stick_in       i_data,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output rdz_pkg::t_stick_out           o_data,
    input  wire logic                     i_cfg_we,
    input  wire logic [rdz_pkg::DZ_W-1:0] i_cfg_data
);
    import rdz_pkg::*;

    localparam logic [DZ_W-1:0] FS = DZ_W'(FULL_SCALE);
    localparam int SB_W  = 2 * AXIS_W + 2;
    // Sideband through the divider: signs, dead-zone flag and zero force.
    localparam int DSB_W = 4;

    logic [DZ_W-1:0] r_dz;
    logic            en;

    // The pipeline advances unless a finished word waits on a stalled receiver.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DZ_RESET;
        end else if (i_cfg_we) begin
            r_dz <= i_cfg_data;
        end
    end

    // Stage 0: absolute values and signs. |-32768| still fits 16 unsigned bits.
    logic              r0_v, r0_sx, r0_sy;
    logic [AXIS_W-1:0] r0_ax, r0_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
        if (en) begin
            r0_sx <= i_data.stick_x[15];
            r0_sy <= i_data.stick_y[15];
            r0_ax <= i_data.stick_x[15] ? AXIS_W'(-i_data.stick_x) : AXIS_W'(i_data.stick_x);
            r0_ay <= i_data.stick_y[15] ? AXIS_W'(-i_data.stick_y) : AXIS_W'(i_data.stick_y);
        end
    end

    // Stage 1: squares.
    logic              r1_v, r1_sx, r1_sy;
    logic [AXIS_W-1:0] r1_ax, r1_ay;
    logic [SUM_W-1:0]  r1_qx, r1_qy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
        if (en) begin
            r1_sx <= r0_sx;
            r1_sy <= r0_sy;
            r1_ax <= r0_ax;
            r1_ay <= r0_ay;
            r1_qx <= r0_ax * r0_ax;
            r1_qy <= r0_ay * r0_ay;
        end
    end

    // Stage 2: sum of squares, at most 2^31.
    logic              r2_v;
    logic [SUM_W-1:0]  r2_sum;
    logic [SB_W-1:0]   r2_sb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_sum <= r1_qx + r1_qy;
            r2_sb  <= {r1_sx, r1_sy, r1_ax, r1_ay};
        end
    end

    logic             sq_v;
    logic [MAG_W-1:0] sq_mag;
    logic [SB_W-1:0]  sq_sb;

    rdz_isqrt #(
        .SB_W (SB_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_sum   (r2_sum),
        .i_sb    (r2_sb),
        .o_valid (sq_v),
        .o_mag   (sq_mag),
        .o_sb    (sq_sb)
    );

    // Stage 3: dead-zone test, distance past the edge, span and axis*FULL_SCALE.
    logic              r3_v, r3_sx, r3_sy, r3_dz, r3_zero;
    logic [MAG_W-1:0]  r3_mag, r3_diff;
    logic [DZ_W-1:0]   r3_span;
    logic [DEN_W-1:0]  r3_nx, r3_ny;
    logic [AXIS_W-1:0] s_ax, s_ay;
    logic              below;

    assign s_ax  = sq_sb[2*AXIS_W-1:AXIS_W];
    assign s_ay  = sq_sb[AXIS_W-1:0];
    assign below = sq_mag < MAG_W'(r_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= sq_v;
        end
        if (en) begin
            r3_sx   <= sq_sb[SB_W-1];
            r3_sy   <= sq_sb[SB_W-2];
            r3_dz   <= below;
            r3_zero <= below || (sq_mag == '0);
            r3_mag  <= sq_mag;
            r3_diff <= sq_mag - MAG_W'(r_dz);
            r3_span <= (r_dz < FS) ? FS - r_dz : DZ_W'(1);
            r3_nx   <= s_ax * FS;
            r3_ny   <= s_ay * FS;
        end
    end

    // Stage 4: numerators and the shared denominator.
    logic              r4_v;
    logic [NUM_W-1:0]  r4_numx, r4_numy;
    logic [DEN_W-1:0]  r4_den;
    logic [DSB_W-1:0]  r4_sb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
        if (en) begin
            r4_numx <= r3_nx * r3_diff;
            r4_numy <= r3_ny * r3_diff;
            r4_den  <= r3_mag * r3_span;
            r4_sb   <= {r3_sx, r3_sy, r3_dz, r3_zero};
        end
    end

    logic [QUO_W-1:0] qx, qy;
    logic             satx, saty;

    rdz_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_numx),
        .i_den (r4_den),
        .o_quo (qx),
        .o_sat (satx)
    );

    rdz_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_numy),
        .i_den (r4_den),
        .o_quo (qy),
        .o_sat (saty)
    );

    // Valid bits and sideband ride alongside the divider stages.
    localparam int DLAT = QUO_W + 1;
    logic             r_dv  [0:DLAT-1];
    logic [DSB_W-1:0] r_dsb [0:DLAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r4_v;
            for (int i = 1; i < DLAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
        if (en) begin
            r_dsb[0] <= r4_sb;
            for (int i = 1; i < DLAT; i++) begin
                r_dsb[i] <= r_dsb[i-1];
            end
        end
    end

    // Output stage: clamp to full scale, restore signs, force zero if needed.
    logic [DSB_W-1:0] fsb;
    logic [QUO_W-1:0] cx, cy;
    assign fsb = r_dsb[DLAT-1];
    assign cx  = (satx || qx > QUO_W'(FS)) ? QUO_W'(FS) : qx;
    assign cy  = (saty || qy > QUO_W'(FS)) ? QUO_W'(FS) : qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_dv[DLAT-1];
        end
        if (en) begin
            o_data.in_dead_zone <= fsb[1];
            if (fsb[0]) begin
                o_data.scaled_x <= '0;
                o_data.scaled_y <= '0;
            end else begin
                o_data.scaled_x <= fsb[3] ? -$signed(cx) : $signed(cx);
                o_data.scaled_y <= fsb[2] ? -$signed(cy) : $signed(cy);
            end
        end
    end

endmodule
`default_nettype wire
